// ===== src/agsp_pkg.sv =====
// ----------------------------------------------------------------------------
// agsp_pkg
// Shared types, defaults and saturating helpers for the gain-scheduled
// PI airbrake controller.
// ----------------------------------------------------------------------------
`default_nettype none

package agsp_pkg;

    // Default parameter values
    localparam int POLY_DEGREE_DEF       = 5;
    localparam int COUNT_LIMIT_DEF       = 10;
    localparam int SAMPLE_PERIOD_Q16_DEF = 655;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_ACT_MACH   = 3'd0,
        REG_DEACT_MACH = 3'd1,
        REG_CUTOFF     = 3'd2,
        REG_SLOPE      = 3'd3,
        REG_FLOOR      = 3'd4,
        REG_TRIM       = 3'd5,
        REG_COEFF_SEL  = 3'd6,
        REG_COEFF_VAL  = 3'd7
    } reg_idx_t;

    // Multiplier request and response
    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] result;
    } mul_rsp_t;

    // Saturating 64-bit add
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

    // Saturating 64-bit negate
    function automatic logic signed [63:0] sat_neg64(input logic signed [63:0] a);
        if (a == {1'b1, 63'd0}) begin
            sat_neg64 = {1'b0, {63{1'b1}}};
        end else begin
            sat_neg64 = -a;
        end
    endfunction

    // Clamp a 64-bit value into signed 32 bits
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] a);
        if (a > 64'sh000000007FFFFFFF) begin
            clamp32 = 32'sh7FFFFFFF;
        end else if (a < -64'sh0000000080000000) begin
            clamp32 = 32'sh80000000;
        end else begin
            clamp32 = a[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/airbrake_gain_scheduled_pi.sv =====
// Each multiply is issued to the shared multiplier and waited on; an active
// sample runs 4*POLY_DEGREE+6 multiplies and four table loads (POLY_DEGREE+1
// multiplies and one load when inactive with apogee latched, none when inactive
// otherwise); the result waits in S_FIN while the output stays blocked.
// Throughput: one word at a time; the next word is taken the cycle after the result
// is registered. Reset (aresetn low, synchronous) clears control state; table not cleared.
// ----------------------------------------------------------------------------
// airbrake_gain_scheduled_pi
// Gain-scheduled PI airbrake controller with Horner gain evaluation over a
// coefficient memory and an altitude-dependent anti-windup clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module airbrake_gain_scheduled_pi #(
    parameter int POLY_DEGREE       = agsp_pkg::POLY_DEGREE_DEF,
    parameter int COUNT_LIMIT       = agsp_pkg::COUNT_LIMIT_DEF,
    parameter int SAMPLE_PERIOD_Q16 = agsp_pkg::SAMPLE_PERIOD_Q16_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready,
    // input words
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_is_coasting,
    input  wire logic [1:0]         s_mach_regime,
    input  wire logic [15:0]        s_mach_number,
    input  wire logic signed [31:0] s_altitude_agl,
    input  wire logic signed [31:0] s_velocity,
    // result words
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [15:0]             m_brake_command,
    output logic signed [31:0]      m_velocity_error,
    output logic signed [31:0]      m_integrator_value,
    output logic signed [31:0]      m_reference_velocity,
    output logic                    m_apogee_phase,
    output logic                    m_control_active
);
    import agsp_pkg::*;

    localparam int NTERMS = POLY_DEGREE + 1;
    localparam int TABLE  = 4 * NTERMS;
    localparam int AW     = $clog2(TABLE);
    localparam int TW     = $clog2(NTERMS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_INIT, S_HMUL, S_HWAIT, S_REF, S_REFW, S_OP, S_OPW, S_FIN
    } state_t;

    // ---------------- configuration registers ----------------
    logic [15:0] act_mach_reg;
    logic [15:0] deact_mach_reg;
    logic [30:0] cutoff_reg;
    logic [30:0] slope_reg;
    logic [30:0] floor_reg;
    logic [15:0] trim_reg;
    logic [4:0]  coeff_sel_reg;
    logic [63:0] coeff_val_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        coef_wen;
    logic [31:0] sel_ext;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];
    assign sel_ext = 32'(coeff_sel_reg);
    assign coef_wen = cfg_wr && (cfg_idx == REG_COEFF_VAL) && (sel_ext < 32'(TABLE));

    // Store register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_mach_reg   <= 16'd0;
            deact_mach_reg <= 16'd0;
            cutoff_reg     <= 31'd0;
            slope_reg      <= 31'd0;
            floor_reg      <= 31'd0;
            trim_reg       <= 16'd0;
            coeff_sel_reg  <= 5'd0;
            coeff_val_reg  <= 64'd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ACT_MACH:   act_mach_reg   <= pwdata[15:0];
                REG_DEACT_MACH: deact_mach_reg <= pwdata[15:0];
                REG_CUTOFF:     cutoff_reg     <= pwdata[30:0];
                REG_SLOPE:      slope_reg      <= pwdata[30:0];
                REG_FLOOR:      floor_reg      <= pwdata[30:0];
                REG_TRIM:       trim_reg       <= pwdata[15:0];
                REG_COEFF_SEL:  coeff_sel_reg  <= pwdata[4:0];
                REG_COEFF_VAL:  coeff_val_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back registers
    always_comb begin
        unique case (cfg_idx)
            REG_ACT_MACH:   prdata = {48'd0, act_mach_reg};
            REG_DEACT_MACH: prdata = {48'd0, deact_mach_reg};
            REG_CUTOFF:     prdata = {33'd0, cutoff_reg};
            REG_SLOPE:      prdata = {33'd0, slope_reg};
            REG_FLOOR:      prdata = {33'd0, floor_reg};
            REG_TRIM:       prdata = {48'd0, trim_reg};
            REG_COEFF_SEL:  prdata = {59'd0, coeff_sel_reg};
            REG_COEFF_VAL:  prdata = coeff_val_reg;
            default:        prdata = 64'd0;
        endcase
    end

    // ---------------- datapath registers ----------------
    state_t             state_reg;
    logic               active_reg;
    logic [15:0]        mach_reg;
    logic signed [31:0] alt_reg;
    logic signed [31:0] vel_reg;
    logic [1:0]         curve_reg;
    logic [TW-1:0]      term_reg;
    logic [2:0]         op_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] g0_reg;
    logic signed [63:0] g1_reg;
    logic signed [63:0] g2_reg;
    logic signed [31:0] ref_reg;
    logic signed [31:0] err_reg;
    logic signed [63:0] u_reg;
    logic [30:0]        bound_reg;
    logic signed [31:0] integ_reg;

    // controller state
    logic [15:0]        last_cmd_reg;
    logic signed [31:0] integral_reg;
    logic [7:0]         count_reg;
    logic               apogee_reg;

    // output registers
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [15:0]        o_cmd_reg;
    logic signed [31:0] o_err_reg;
    logic signed [31:0] o_integ_reg;
    logic signed [31:0] o_ref_reg;
    logic               o_apogee_reg;
    logic               o_active_reg;

    // ---------------- memory and multiplier ----------------
    logic               mem_ren;
    logic [AW-1:0]      mem_raddr;
    logic [63:0]        mem_rdata;
    mul_req_t           mreq;
    mul_rsp_t           mrsp;

    agsp_coef_ram #(.DEPTH(TABLE), .AW(AW)) u_ram (
        .aclk  (aclk),
        .wen   (coef_wen),
        .waddr (sel_ext[AW-1:0]),
        .wdata (pwdata),
        .ren   (mem_ren),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    agsp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    // ---------------- combinational helpers ----------------
    logic               accept;
    logic               take_out;
    logic               sample_active;
    logic signed [63:0] alt64;
    logic signed [17:0] cmd_diff;
    logic signed [63:0] diff64;
    logic signed [63:0] prev64;
    logic signed [63:0] cut_minus_alt;
    logic signed [63:0] horner_sum;
    logic signed [31:0] ref_new;
    logic signed [32:0] err_wide;
    logic signed [31:0] err_new;
    logic signed [63:0] neg_r;
    logic signed [63:0] u_step;
    logic signed [63:0] u_clamped;
    logic [63:0]        u_round;
    logic [30:0]        bound_new;
    logic signed [63:0] integ_sum;
    logic signed [63:0] bound64;
    logic signed [31:0] integ_new;
    logic [7:0]         count_new;
    logic               apogee_new;
    logic [31:0]        rd_addr;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign take_out = !m_valid_reg || m_ready;
    assign sample_active = s_is_coasting && !s_mach_regime[1] &&
                           (s_mach_number < act_mach_reg) && !apogee_reg;

    assign alt64    = 64'(alt_reg);
    assign cmd_diff = $signed({2'b00, last_cmd_reg}) - $signed({2'b00, trim_reg});
    assign diff64   = {{45{cmd_diff[17]}}, cmd_diff, 1'b0};
    assign prev64   = {31'd0, last_cmd_reg, 17'd0};
    assign cut_minus_alt = $signed({33'd0, cutoff_reg}) - alt64;

    // Memory read address: curve base plus term (term is zero on load)
    assign rd_addr   = 32'(curve_reg) * 32'(NTERMS) +
                       ((state_reg == S_LOAD) ? 32'd0 : 32'(term_reg));
    assign mem_raddr = rd_addr[AW-1:0];
    assign mem_ren   = (state_reg == S_LOAD) || (state_reg == S_HMUL);

    // Multiplier operand select
    always_comb begin
        mreq.start = (state_reg == S_HMUL) || (state_reg == S_REF) || (state_reg == S_OP);
        mreq.a     = acc_reg;
        mreq.b     = alt64;
        if (state_reg == S_REF) begin
            mreq.b = 64'sd1;
        end else if (state_reg == S_OP) begin
            case (op_reg)
                3'd0: begin mreq.a = g0_reg; mreq.b = 64'(err_reg); end
                3'd1: begin mreq.a = g1_reg; mreq.b = 64'(integral_reg); end
                3'd2: begin mreq.a = g2_reg; mreq.b = diff64; end
                3'd3: begin mreq.a = {33'd0, slope_reg}; mreq.b = cut_minus_alt; end
                default: begin mreq.a = 64'(SAMPLE_PERIOD_Q16); mreq.b = 64'(err_reg); end
            endcase
        end
    end

    // Horner step, reference and error
    assign horner_sum = sat_add64(mrsp.result, mem_rdata);
    assign ref_new    = clamp32(mrsp.result);
    assign err_wide   = 33'(vel_reg) - 33'(ref_new);

    always_comb begin
        if (ref_new[31]) begin
            err_new = vel_reg;
        end else if (err_wide > 33'sh07FFFFFFF) begin
            err_new = 32'sh7FFFFFFF;
        end else if (err_wide < -33'sh080000000) begin
            err_new = 32'sh80000000;
        end else begin
            err_new = err_wide[31:0];
        end
    end

    // Command terms
    assign neg_r = sat_neg64(mrsp.result);
    always_comb begin
        case (op_reg)
            3'd0:    u_step = neg_r;
            3'd1:    u_step = sat_add64(u_reg, neg_r);
            default: u_step = sat_add64(sat_add64(u_reg, neg_r), prev64);
        endcase
    end

    // Anti-windup bound
    always_comb begin
        if (alt64 > $signed({33'd0, cutoff_reg})) begin
            bound_new = 31'd0;
        end else if (mrsp.result < $signed({33'd0, floor_reg})) begin
            bound_new = floor_reg;
        end else if (mrsp.result > 64'sh000000007FFFFFFF) begin
            bound_new = {31{1'b1}};
        end else begin
            bound_new = mrsp.result[30:0];
        end
    end

    // Integrator update under the bound
    assign integ_sum = 64'(integral_reg) + mrsp.result;
    assign bound64   = {33'd0, bound_reg};
    always_comb begin
        if (integ_sum > bound64) begin
            integ_new = 32'(bound64);
        end else if (integ_sum < -bound64) begin
            integ_new = 32'(-bound64);
        end else begin
            integ_new = integ_sum[31:0];
        end
    end

    // Command clamp and rounding to Q1.15
    always_comb begin
        if (u_reg < 64'sd0) begin
            u_clamped = 64'sd0;
        end else if (u_reg > 64'sh0000000100000000) begin
            u_clamped = 64'sh0000000100000000;
        end else begin
            u_clamped = u_reg;
        end
    end
    assign u_round = 64'(u_clamped) + 64'd65536;

    // Slow sample counter and apogee latch
    assign count_new  = ((mach_reg < deact_mach_reg) && (count_reg != 8'hFF)) ?
                        count_reg + 8'd1 : count_reg;
    assign apogee_new = apogee_reg || (32'(count_new) >= 32'(COUNT_LIMIT));

    // Output valid: set on commit, drop once the word is taken
    always_comb begin
        if (state_reg == S_FIN && take_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            last_cmd_reg <= 16'd0;
            integral_reg <= 32'sd0;
            count_reg    <= 8'd0;
            apogee_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        active_reg <= sample_active;
                        mach_reg   <= s_mach_number;
                        alt_reg    <= s_altitude_agl;
                        vel_reg    <= s_velocity;
                        ref_reg    <= 32'sd0;
                        err_reg    <= 32'sd0;
                        integ_reg  <= 32'sd0;
                        u_reg      <= 64'sd0;
                        curve_reg  <= sample_active ? 2'd0 : 2'd3;
                        if (sample_active || apogee_reg) begin
                            state_reg <= S_LOAD;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_LOAD: state_reg <= S_INIT;
                S_INIT: begin
                    acc_reg   <= mem_rdata;
                    term_reg  <= TW'(1);
                    state_reg <= S_HMUL;
                end
                S_HMUL: state_reg <= S_HWAIT;
                S_HWAIT: begin
                    if (mrsp.done) begin
                        acc_reg <= horner_sum;
                        if (32'(term_reg) == POLY_DEGREE) begin
                            case (curve_reg)
                                2'd0:    g0_reg <= horner_sum;
                                2'd1:    g1_reg <= horner_sum;
                                2'd2:    g2_reg <= horner_sum;
                                default: ;
                            endcase
                            if (curve_reg == 2'd3) begin
                                state_reg <= S_REF;
                            end else begin
                                curve_reg <= curve_reg + 2'd1;
                                state_reg <= S_LOAD;
                            end
                        end else begin
                            term_reg  <= term_reg + TW'(1);
                            state_reg <= S_HMUL;
                        end
                    end
                end
                S_REF: state_reg <= S_REFW;
                S_REFW: begin
                    if (mrsp.done) begin
                        ref_reg <= ref_new;
                        err_reg <= err_new;
                        op_reg  <= 3'd0;
                        state_reg <= active_reg ? S_OP : S_FIN;
                    end
                end
                S_OP: state_reg <= S_OPW;
                S_OPW: begin
                    if (mrsp.done) begin
                        case (op_reg)
                            3'd3:    bound_reg <= bound_new;
                            3'd4:    integ_reg <= integ_new;
                            default: u_reg     <= u_step;
                        endcase
                        if (op_reg == 3'd4) begin
                            state_reg <= S_FIN;
                        end else begin
                            op_reg    <= op_reg + 3'd1;
                            state_reg <= S_OP;
                        end
                    end
                end
                S_FIN: begin
                    // commit state and present the result word
                    if (take_out) begin
                        o_err_reg    <= err_reg;
                        o_ref_reg    <= ref_reg;
                        o_active_reg <= active_reg;
                        if (active_reg) begin
                            last_cmd_reg <= u_round[32:17];
                            integral_reg <= integ_reg;
                            count_reg    <= count_new;
                            apogee_reg   <= apogee_new;
                            o_cmd_reg    <= u_round[32:17];
                            o_integ_reg  <= integ_reg;
                            o_apogee_reg <= apogee_new;
                        end else begin
                            last_cmd_reg <= 16'd0;
                            integral_reg <= 32'sd0;
                            o_cmd_reg    <= 16'd0;
                            o_integ_reg  <= 32'sd0;
                            o_apogee_reg <= apogee_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_brake_command      = o_cmd_reg;
    assign m_velocity_error     = o_err_reg;
    assign m_integrator_value   = o_integ_reg;
    assign m_reference_velocity = o_ref_reg;
    assign m_apogee_phase       = o_apogee_reg;
    assign m_control_active     = o_active_reg;

    // ---------------- assertions ----------------
    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (o_cmd_reg <= 16'd32768))
        else $error("brake command above full scale");

    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !o_active_reg) |-> (o_cmd_reg == 16'd0 && o_integ_reg == 32'sd0))
        else $error("inactive word carries command or integrator");

    a_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.start |-> !mrsp.busy)
        else $error("multiplier started while busy");

    a_apogee_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        apogee_reg |=> apogee_reg)
        else $error("apogee phase dropped");

    a_inactive_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && !active_reg && take_out) |=> (last_cmd_reg == 16'd0))
        else $error("last command not cleared on inactive sample");

endmodule

`default_nettype wire

// ===== src/agsp_mul.sv =====
// ----------------------------------------------------------------------------
// agsp_mul
// Multi-cycle signed 64x64 multiplier: round(a*b / 2^16), ties away from
// zero, saturated to signed 64 bits. One 32x32 partial product a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module agsp_mul (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  agsp_pkg::mul_req_t    req,
    output agsp_pkg::mul_rsp_t    rsp
);
    import agsp_pkg::*;

    typedef enum logic [2:0] {M_IDLE, M_PROD, M_LAST, M_RND, M_SAT} mstate_t;

    mstate_t       state_reg;
    logic [1:0]    step_reg;
    logic          neg_reg;
    logic [63:0]   ma_reg;
    logic [63:0]   mb_reg;
    logic [63:0]   pp_reg;
    logic [1:0]    pp_step_reg;
    logic [127:0]  acc_reg;
    logic [111:0]  q_reg;
    logic          done_reg;
    logic [63:0]   result_reg;

    logic [31:0]   op_a;
    logic [31:0]   op_b;
    logic [127:0]  pp_shifted;
    logic [127:0]  rnd_sum;
    logic [63:0]   limit;
    logic [63:0]   q_sat;

    // Select operand halves for this step
    always_comb begin
        op_a = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        op_b = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
    end

    // Align the previous partial product
    always_comb begin
        case (pp_step_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd3:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = {32'd0, pp_reg, 32'd0};
        endcase
    end

    assign rnd_sum = acc_reg + 128'd32768;
    assign limit   = neg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};

    always_comb begin
        if (q_reg[111:64] != 48'd0 || q_reg[63:0] > limit) begin
            q_sat = limit;
        end else begin
            q_sat = q_reg[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            step_reg  <= 2'd0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (req.start) begin
                        neg_reg   <= req.a[63] ^ req.b[63];
                        ma_reg    <= req.a[63] ? 64'(-req.a) : req.a;
                        mb_reg    <= req.b[63] ? 64'(-req.b) : req.b;
                        acc_reg   <= 128'd0;
                        step_reg  <= 2'd0;
                        state_reg <= M_PROD;
                    end
                end
                M_PROD: begin
                    // multiply one pair of halves, accumulate the one before
                    pp_reg      <= op_a * op_b;
                    pp_step_reg <= step_reg;
                    if (step_reg != 2'd0) begin
                        acc_reg <= acc_reg + pp_shifted;
                    end
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3) begin
                        state_reg <= M_LAST;
                    end
                end
                M_LAST: begin
                    acc_reg   <= acc_reg + pp_shifted;
                    state_reg <= M_RND;
                end
                M_RND: begin
                    q_reg     <= rnd_sum[127:16];
                    state_reg <= M_SAT;
                end
                M_SAT: begin
                    result_reg <= neg_reg ? 64'(-q_sat) : q_sat;
                    done_reg   <= 1'b1;
                    state_reg  <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign rsp.busy   = (state_reg != M_IDLE);
    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire

// ===== src/agsp_coef_ram.sv =====
// ----------------------------------------------------------------------------
// agsp_coef_ram
// Coefficient table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module agsp_coef_ram #(
    parameter int DEPTH = 24,
    parameter int AW    = 5
) (
    input  wire logic          aclk,
    input  wire logic          wen,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [63:0]   wdata,
    input  wire logic          ren,
    input  wire logic [AW-1:0] raddr,
    output logic [63:0]        rdata
);
    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    // Write a coefficient
    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
    end

    // Read, hold data until the next read
    always_ff @(posedge aclk) begin
        if (ren) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
